// ===== rtl/c_subset_lexer_defines.svh =====
// Assertion macros shared by the lexer RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef C_SUBSET_LEXER_DEFINES_SVH
`define C_SUBSET_LEXER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define CLEX_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define CLEX_IMPLY(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define CLEX_IMPLY_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/clex_pkg.sv =====
// Shared types, constants and character classes for the C subset lexer.
// No dependencies; imported by every lexer module.
`timescale 1ns / 1ps

package clex_pkg;

  localparam int PREFIX_DEPTH = 5;
  localparam int PIDX_BITS    = $clog2(PREFIX_DEPTH);
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0]  CH_EQ   = "=";
  localparam logic [7:0]  CH_BANG = "!";
  localparam logic [7:0]  CH_ZERO = "0";
  localparam logic [15:0] KW_IF    = "if";
  localparam logic [31:0] KW_ELSE  = "else";
  localparam logic [39:0] KW_WHILE = "while";
  localparam logic [23:0] KW_INT   = "int";
  localparam logic [15:0] LEN_MAX  = 16'hFFFF;
  localparam logic [31:0] NUM_MAX  = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_NUM,
    MODE_WORD,
    MODE_EQ,
    MODE_BANG,
    MODE_ERR
  } mode_e;

  typedef enum logic [4:0] {
    KIND_NUM    = 5'd0,
    KIND_IDENT  = 5'd1,
    KIND_IF     = 5'd2,
    KIND_ELSE   = 5'd3,
    KIND_WHILE  = 5'd4,
    KIND_INT    = 5'd5,
    KIND_EQ     = 5'd6,
    KIND_NE     = 5'd7,
    KIND_ASSIGN = 5'd8,
    KIND_PLUS   = 5'd9,
    KIND_MINUS  = 5'd10,
    KIND_STAR   = 5'd11,
    KIND_SLASH  = 5'd12,
    KIND_LPAREN = 5'd13,
    KIND_RPAREN = 5'd14,
    KIND_LBRACE = 5'd15,
    KIND_RBRACE = 5'd16,
    KIND_SEMI   = 5'd17,
    KIND_COMMA  = 5'd18,
    KIND_EOF    = 5'd19,
    KIND_ERROR  = 5'd20
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] value;
    logic        sat;
    logic [15:0] start;
    logic [15:0] length;
    logic        last;
  } token_t;

  // Up to two tokens handed from the lexer to the output queue per word.
  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } push_t;

  typedef struct packed {
    logic  hit;
    kind_e kind;
  } single_t;

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c == "_");
  endfunction

  function automatic single_t single_lookup(logic [7:0] c);
    single_t r;
    r.hit = 1'b1;
    case (c)
      "+":     r.kind = KIND_PLUS;
      "-":     r.kind = KIND_MINUS;
      "*":     r.kind = KIND_STAR;
      "/":     r.kind = KIND_SLASH;
      "(":     r.kind = KIND_LPAREN;
      ")":     r.kind = KIND_RPAREN;
      "{":     r.kind = KIND_LBRACE;
      "}":     r.kind = KIND_RBRACE;
      ";":     r.kind = KIND_SEMI;
      ",":     r.kind = KIND_COMMA;
      default: begin
        r.hit  = 1'b0;
        r.kind = KIND_ERROR;
      end
    endcase
    return r;
  endfunction

  // Keywords need an exact length match against the stored prefix.
  function automatic kind_e word_kind(logic [PREFIX_DEPTH-1:0][7:0] pre, logic [15:0] len);
    kind_e k;
    k = KIND_IDENT;
    if (len == 16'd2 && {pre[0], pre[1]} == KW_IF) begin
      k = KIND_IF;
    end else if (len == 16'd4 && {pre[0], pre[1], pre[2], pre[3]} == KW_ELSE) begin
      k = KIND_ELSE;
    end else if (len == 16'd5 && {pre[0], pre[1], pre[2], pre[3], pre[4]} == KW_WHILE) begin
      k = KIND_WHILE;
    end else if (len == 16'd3 && {pre[0], pre[1], pre[2]} == KW_INT) begin
      k = KIND_INT;
    end
    return k;
  endfunction

  function automatic token_t make_token(kind_e kind, logic [31:0] value, logic sat,
                                        logic [15:0] start, logic [15:0] length);
    token_t t;
    t.kind   = kind;
    t.value  = value;
    t.sat    = sat;
    t.start  = start;
    t.length = length;
    t.last   = 1'b0;
    return t;
  endfunction

endpackage

// ===== rtl/clex_lexer.sv =====
// Input register, lexer state and the single-pass step logic.
// Depends on clex_pkg; hands 0 to 2 tokens per word to the output queue.
`timescale 1ns / 1ps
`include "c_subset_lexer_defines.svh"

module clex_lexer import clex_pkg::*; #(
  parameter int POSITION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_code_i,
  input  logic        end_of_input_i,
  input  logic        space_ok_i,
  output push_t       push_o
);

  localparam int StartBits = (POSITION_BITS < 16) ? POSITION_BITS : 16;

  logic                              in_valid_q;
  logic [7:0]                        char_q;
  logic                              eoi_q;
  mode_e                             mode_q, mode_d;
  logic [31:0]                       acc_q, acc_d;
  logic                              sat_q, sat_d;
  logic [PREFIX_DEPTH-1:0][7:0]      prefix_q;
  logic [StartBits-1:0]              start_q, start_d;
  logic [15:0]                       len_q, len_d;
  logic [POSITION_BITS-1:0]          pos_q, pos_d;

  logic                              accept;
  logic                              proc;
  logic                              pf_we;
  logic [PIDX_BITS-1:0]              pf_idx;
  logic [3:0]                        digit;
  logic [35:0]                       acc_x10;
  logic [15:0]                       pos16;
  logic [15:0]                       len_grown;
  single_t                           sc;
  token_t                            flush_tok;
  logic                              flush_hit;
  token_t                            t0, t1;
  logic                              v0, v1;
  logic                              do_start;

  assign accept     = in_valid_i && !in_stall_o;
  assign proc       = in_valid_q && space_ok_i;
  assign in_stall_o = in_valid_q && !space_ok_i;

  assign digit     = 4'(char_q - CH_ZERO);
  assign acc_x10   = 36'({acc_q, 3'b000}) + 36'({acc_q, 1'b0}) + 36'(digit);
  assign pos16     = 16'(pos_q);
  assign len_grown = (len_q != LEN_MAX) ? len_q + 16'd1 : len_q;
  assign sc        = single_lookup(char_q);

  // Token that the pending state gives when it ends.
  always_comb begin
    flush_hit = 1'b1;
    case (mode_q)
      MODE_NUM:  flush_tok = make_token(KIND_NUM, acc_q, sat_q, 16'(start_q), len_q);
      MODE_WORD: flush_tok = make_token(word_kind(prefix_q, len_q), 32'd0, 1'b0,
                                        16'(start_q), len_q);
      MODE_EQ:   flush_tok = make_token(KIND_ASSIGN, 32'd0, 1'b0, 16'(start_q), 16'd1);
      MODE_BANG: flush_tok = make_token(KIND_ERROR, 32'(CH_BANG), 1'b0, 16'(start_q), 16'd1);
      default: begin
        flush_hit = 1'b0;
        flush_tok = '0;
      end
    endcase
  end

  always_comb begin
    mode_d   = mode_q;
    acc_d    = acc_q;
    sat_d    = sat_q;
    start_d  = start_q;
    len_d    = len_q;
    pos_d    = pos_q;
    pf_we    = 1'b0;
    pf_idx   = '0;
    t0       = '0;
    t1       = '0;
    v0       = 1'b0;
    v1       = 1'b0;
    do_start = 1'b0;
    if (proc) begin
      if (eoi_q) begin
        t0      = flush_tok;
        v0      = flush_hit;
        t1      = make_token(KIND_EOF, 32'd0, 1'b0, pos16, 16'd0);
        v1      = 1'b1;
        mode_d  = MODE_IDLE;
        acc_d   = '0;
        sat_d   = 1'b0;
        start_d = '0;
        len_d   = '0;
        pos_d   = '0;
      end else begin
        pos_d = pos_q + 1'b1;
        case (mode_q)
          MODE_ERR: begin
          end
          MODE_NUM: begin
            if (is_digit(char_q)) begin
              if (acc_x10[35:32] != 4'd0) begin
                acc_d = NUM_MAX;
                sat_d = 1'b1;
              end else begin
                acc_d = acc_x10[31:0];
              end
              len_d = len_grown;
            end else begin
              t0       = flush_tok;
              v0       = 1'b1;
              do_start = 1'b1;
            end
          end
          MODE_WORD: begin
            if (is_alpha(char_q) || is_digit(char_q)) begin
              if (len_q < 16'(PREFIX_DEPTH)) begin
                pf_we  = 1'b1;
                pf_idx = PIDX_BITS'(len_q);
              end
              len_d = len_grown;
            end else begin
              t0       = flush_tok;
              v0       = 1'b1;
              do_start = 1'b1;
            end
          end
          MODE_EQ: begin
            if (char_q == CH_EQ) begin
              t0     = make_token(KIND_EQ, 32'd0, 1'b0, 16'(start_q), 16'd2);
              v0     = 1'b1;
              mode_d = MODE_IDLE;
            end else begin
              t0       = flush_tok;
              v0       = 1'b1;
              do_start = 1'b1;
            end
          end
          MODE_BANG: begin
            if (char_q == CH_EQ) begin
              t0     = make_token(KIND_NE, 32'd0, 1'b0, 16'(start_q), 16'd2);
              v0     = 1'b1;
              mode_d = MODE_IDLE;
            end else begin
              // Lone bang: report it and drop this byte.
              t0     = flush_tok;
              v0     = 1'b1;
              mode_d = MODE_ERR;
            end
          end
          default: begin
            do_start = 1'b1;
          end
        endcase

        // Open a new token with this byte.
        if (do_start) begin
          mode_d = MODE_IDLE;
          if (!is_space(char_q)) begin
            start_d = StartBits'(pos_q);
            len_d   = 16'd1;
            if (char_q == CH_EQ) begin
              mode_d = MODE_EQ;
            end else if (char_q == CH_BANG) begin
              mode_d = MODE_BANG;
            end else if (sc.hit) begin
              t1 = make_token(sc.kind, 32'd0, 1'b0, pos16, 16'd1);
              v1 = 1'b1;
            end else if (is_digit(char_q)) begin
              mode_d = MODE_NUM;
              acc_d  = 32'(digit);
              sat_d  = 1'b0;
            end else if (is_alpha(char_q)) begin
              mode_d = MODE_WORD;
              pf_we  = 1'b1;
              pf_idx = '0;
            end else begin
              t1     = make_token(KIND_ERROR, 32'(char_q), 1'b0, pos16, 16'd1);
              v1     = 1'b1;
              mode_d = MODE_ERR;
            end
          end
        end
      end
    end
  end

  // Pack the tokens at the front and flag the last one of this word.
  always_comb begin
    push_o = '0;
    if (v0 && v1) begin
      push_o.count       = 2'd2;
      push_o.first       = t0;
      push_o.second      = t1;
      push_o.second.last = 1'b1;
    end else if (v0) begin
      push_o.count      = 2'd1;
      push_o.first      = t0;
      push_o.first.last = 1'b1;
    end else if (v1) begin
      push_o.count      = 2'd1;
      push_o.first      = t1;
      push_o.first.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      mode_q     <= MODE_IDLE;
      acc_q      <= '0;
      sat_q      <= 1'b0;
      start_q    <= '0;
      len_q      <= '0;
      pos_q      <= '0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (proc) begin
        in_valid_q <= 1'b0;
      end
      mode_q  <= mode_d;
      acc_q   <= acc_d;
      sat_q   <= sat_d;
      start_q <= start_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      char_q <= char_code_i;
      eoi_q  <= end_of_input_i;
    end
    if (pf_we) begin
      prefix_q[pf_idx] <= char_q;
    end
  end

  `CLEX_IMPLY_NEXT(a_eof_rewinds, proc && eoi_q, pos_q == '0 && mode_q == MODE_IDLE, "no rewind")
  `CLEX_IMPLY(a_push_on_step, push_o.count != 2'd0, proc, "tokens pushed without a word")
  `CLEX_IMPLY(a_err_quiet, proc && !eoi_q && mode_q == MODE_ERR, push_o.count == '0, "error token")

endmodule

// ===== rtl/clex_outq.sv =====
// Four-entry token queue: takes up to two tokens per cycle, gives one unless stalled.
// Depends on clex_pkg; its head entry drives the result ports.
`timescale 1ns / 1ps
`include "c_subset_lexer_defines.svh"

module clex_outq import clex_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  push_t  push_i,
  output logic   space_ok_o,
  output logic   out_valid_o,
  input  logic   out_stall_i,
  output token_t head_o
);

  token_t               mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_BITS-1:0] count_q, count_d;
  logic                 pop;

  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign head_o      = mem_q[rd_ptr_q];
  // Room for a full two-token word, whatever the consumer does.
  assign space_ok_o  = (count_q <= QCNT_BITS'(QUEUE_DEPTH - 2));
  assign count_d     = count_q + QCNT_BITS'(push_i.count) - QCNT_BITS'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPTR_BITS'(push_i.count);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[QPTR_BITS'(wr_ptr_q + 1'b1)] <= push_i.second;
    end
  end

  `CLEX_ASSERT(a_count_max, count_q <= QCNT_BITS'(QUEUE_DEPTH), "token queue overfilled")
  `CLEX_IMPLY(a_push_room, push_i.count != 2'd0, space_ok_o, "tokens pushed without room")
  `CLEX_IMPLY(a_last_pair, push_i.count == 2'd2, push_i.second.last && !push_i.first.last, "bad last flag on a token pair")
  `CLEX_IMPLY(a_last_single, push_i.count == 2'd1, push_i.first.last, "single token lacks last flag")

endmodule

// ===== rtl/c_subset_lexer.sv =====
// Top level of the streaming C subset lexer.
// Depends on clex_pkg, clex_lexer and clex_outq.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------------
//   in      | input     | in_valid_i/in_stall_o  | char_code, end_of_input
//   out     | output    | out_valid_o/out_stall_i| token_kind, number_value,
//           |           |                        | value_saturated, token_start,
//           |           |                        | token_length, last_of_item
//
// One source byte per cycle unless in_stall_o is high: a word is held in the input register,
// then the step logic updates the lexer state and pushes 0 to 2 tokens into a four-entry
// queue. Tokens leave at one per cycle while out_stall_i is low. The queue needs room for
// two tokens to proceed. Reset clears all control state; the end marker also rewinds the
// lexer and the position. out_stall_i backs up the queue and then in_stall_o; no token is
// dropped.
`timescale 1ns / 1ps

module c_subset_lexer import clex_pkg::*; #(
  parameter int POSITION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_code_i,
  input  logic        end_of_input_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  token_kind_o,
  output logic [31:0] number_value_o,
  output logic        value_saturated_o,
  output logic [15:0] token_start_o,
  output logic [15:0] token_length_o,
  output logic        last_of_item_o
);

  push_t  push;
  logic   space_ok;
  token_t head;

  clex_lexer #(
    .POSITION_BITS(POSITION_BITS)
  ) u_lexer (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_code_i    (char_code_i),
    .end_of_input_i (end_of_input_i),
    .space_ok_i     (space_ok),
    .push_o         (push)
  );

  clex_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_ok_o  (space_ok),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign token_kind_o      = head.kind;
  assign number_value_o    = head.value;
  assign value_saturated_o = head.sat;
  assign token_start_o     = head.start;
  assign token_length_o    = head.length;
  assign last_of_item_o    = head.last;

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for c_subset_lexer: drives source bytes and end markers,
// predicts each token in SystemVerilog and compares the DUT's tokens field by field.
// Depends on clex_pkg and the c_subset_lexer RTL.
`timescale 1ns / 1ps

module testbench;
  import clex_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_WORDS = 1500;
  localparam int TOTAL_WORDS  = 1850;

  logic        clk = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  char_code = 8'd0;
  logic        end_of_input = 1'b0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [4:0]  token_kind;
  logic [31:0] number_value;
  logic        value_saturated;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic        last_of_item;

  c_subset_lexer dut (
    .clk_i             (clk),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .char_code_i       (char_code),
    .end_of_input_i    (end_of_input),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .token_kind_o      (token_kind),
    .number_value_o    (number_value),
    .value_saturated_o (value_saturated),
    .token_start_o     (token_start),
    .token_length_o    (token_length),
    .last_of_item_o    (last_of_item)
  );

  always #10 clk = ~clk;

  // Lexer state as the predictor sees it.
  mode_e       lx_mode;
  logic [31:0] lx_value;
  logic        lx_sat;
  logic [7:0]  lx_prefix [5];
  logic [15:0] lx_start;
  logic [15:0] lx_len;
  logic [15:0] lx_pos;

  token_t step_tokens[$];
  token_t expected_tokens[$];
  token_t oldest_token;

  int  mismatch_count = 0;
  int  words_sent = 0;
  int  cycle_count = 0;
  bit  idling_on = 1'b1;
  int  hold_trigger = 0;
  int  hold_seen = 0;
  int  hold_left = 0;
  int  stall_left = 0;

  function automatic bit char_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit char_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic void add_token(kind_e k, logic [31:0] v, logic s, logic [15:0] st,
                                    logic [15:0] n);
    token_t t;
    t.kind   = k;
    t.value  = v;
    t.sat    = s;
    t.start  = st;
    t.length = n;
    t.last   = 1'b0;
    step_tokens.push_back(t);
  endfunction

  function automatic void rewind_lexer();
    lx_mode  = MODE_IDLE;
    lx_value = 32'd0;
    lx_sat   = 1'b0;
    lx_start = 16'd0;
    lx_len   = 16'd0;
    lx_pos   = 16'd0;
  endfunction

  function automatic void stretch();
    if (lx_len != LEN_MAX) lx_len = lx_len + 16'd1;
  endfunction

  function automatic void flush_pending();
    kind_e k;
    case (lx_mode)
      MODE_NUM: begin
        add_token(KIND_NUM, lx_value, lx_sat, lx_start, lx_len);
        lx_mode = MODE_IDLE;
      end
      MODE_WORD: begin
        // Keywords need the exact length; longer words keep only five bytes.
        k = KIND_IDENT;
        if (lx_len == 16'd2 && lx_prefix[0] == "i" && lx_prefix[1] == "f") begin
          k = KIND_IF;
        end else if (lx_len == 16'd4 && lx_prefix[0] == "e" && lx_prefix[1] == "l" &&
                     lx_prefix[2] == "s" && lx_prefix[3] == "e") begin
          k = KIND_ELSE;
        end else if (lx_len == 16'd5 && lx_prefix[0] == "w" && lx_prefix[1] == "h" &&
                     lx_prefix[2] == "i" && lx_prefix[3] == "l" && lx_prefix[4] == "e") begin
          k = KIND_WHILE;
        end else if (lx_len == 16'd3 && lx_prefix[0] == "i" && lx_prefix[1] == "n" &&
                     lx_prefix[2] == "t") begin
          k = KIND_INT;
        end
        add_token(k, 32'd0, 1'b0, lx_start, lx_len);
        lx_mode = MODE_IDLE;
      end
      MODE_EQ: begin
        add_token(KIND_ASSIGN, 32'd0, 1'b0, lx_start, 16'd1);
        lx_mode = MODE_IDLE;
      end
      MODE_BANG: begin
        add_token(KIND_ERROR, {24'd0, CH_BANG}, 1'b0, lx_start, 16'd1);
        lx_mode = MODE_ERR;
      end
      default: ;
    endcase
  endfunction

  function automatic void begin_token(logic [7:0] c, logic [15:0] p);
    kind_e k;
    if (c == 8'd32 || (c >= 8'd9 && c <= 8'd13)) return;
    lx_start = p;
    lx_len   = 16'd1;
    case (c)
      "+":     k = KIND_PLUS;
      "-":     k = KIND_MINUS;
      "*":     k = KIND_STAR;
      "/":     k = KIND_SLASH;
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      "{":     k = KIND_LBRACE;
      "}":     k = KIND_RBRACE;
      ";":     k = KIND_SEMI;
      ",":     k = KIND_COMMA;
      default: k = KIND_ERROR;
    endcase
    if (c == CH_EQ) begin
      lx_mode = MODE_EQ;
    end else if (c == CH_BANG) begin
      lx_mode = MODE_BANG;
    end else if (k != KIND_ERROR) begin
      add_token(k, 32'd0, 1'b0, p, 16'd1);
    end else if (char_digit(c)) begin
      lx_mode  = MODE_NUM;
      lx_value = {24'd0, c - CH_ZERO};
      lx_sat   = 1'b0;
    end else if (char_letter(c)) begin
      lx_mode      = MODE_WORD;
      lx_prefix[0] = c;
    end else begin
      add_token(KIND_ERROR, {24'd0, c}, 1'b0, p, 16'd1);
      lx_mode = MODE_ERR;
    end
  endfunction

  // Work out the tokens that one accepted word causes and queue them.
  function automatic void lex_step(logic [7:0] c, logic eoi);
    logic [15:0] p;
    logic [63:0] grown;
    token_t      t;
    step_tokens.delete();
    p = lx_pos;
    if (eoi) begin
      flush_pending();
      add_token(KIND_EOF, 32'd0, 1'b0, p, 16'd0);
      rewind_lexer();
    end else begin
      case (lx_mode)
        MODE_ERR: ;
        MODE_NUM: begin
          if (char_digit(c)) begin
            grown = {32'd0, lx_value} * 64'd10 + {56'd0, c - CH_ZERO};
            if (grown > {32'd0, NUM_MAX}) begin
              lx_value = NUM_MAX;
              lx_sat   = 1'b1;
            end else begin
              lx_value = grown[31:0];
            end
            stretch();
          end else begin
            flush_pending();
            begin_token(c, p);
          end
        end
        MODE_WORD: begin
          if (char_letter(c) || char_digit(c)) begin
            if (lx_len < 16'd5) lx_prefix[lx_len] = c;
            stretch();
          end else begin
            flush_pending();
            begin_token(c, p);
          end
        end
        MODE_EQ: begin
          if (c == CH_EQ) begin
            add_token(KIND_EQ, 32'd0, 1'b0, lx_start, 16'd2);
            lx_mode = MODE_IDLE;
          end else begin
            flush_pending();
            begin_token(c, p);
          end
        end
        MODE_BANG: begin
          // The byte after a lone bang is dropped.
          if (c == CH_EQ) begin
            add_token(KIND_NE, 32'd0, 1'b0, lx_start, 16'd2);
            lx_mode = MODE_IDLE;
          end else begin
            flush_pending();
          end
        end
        default: begin
          lx_mode = MODE_IDLE;
          begin_token(c, p);
        end
      endcase
      lx_pos = p + 16'd1;
    end
    if (step_tokens.size() > 0) begin
      t = step_tokens.pop_back();
      t.last = 1'b1;
      step_tokens.push_back(t);
    end
    foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_tokens.size() == 0) begin
        $display("%0t ns: token kind %0d arrived, expected none", $time, token_kind);
        mismatch_count++;
      end else begin
        oldest_token = expected_tokens.pop_front();
        check_field("token_kind", {27'd0, oldest_token.kind}, {27'd0, token_kind});
        check_field("number_value", oldest_token.value, number_value);
        check_field("value_saturated", {31'd0, oldest_token.sat}, {31'd0, value_saturated});
        check_field("token_start", {16'd0, oldest_token.start}, {16'd0, token_start});
        check_field("token_length", {16'd0, oldest_token.length}, {16'd0, token_length});
        check_field("last_of_item", {31'd0, oldest_token.last}, {31'd0, last_of_item});
      end
    end
  end

  // Receiver: random stall bursts, plus a long hold on request.
  always @(posedge clk) begin
    if (hold_trigger != hold_seen) begin
      hold_seen = hold_trigger;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 10);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t ns: timeout after %0d cycles", $time, cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offer one word, hold it until accepted, then predict.
  task automatic send_byte(logic [7:0] c, logic eoi);
    int gap;
    if (idling_on && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    char_code    <= c;
    end_of_input <= eoi;
    do @(posedge clk); while (in_stall);
    words_sent++;
    lex_step(c, eoi);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic end_source();
    send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic logic [7:0] word_char(bit first);
    int unsigned r;
    r = first ? $urandom_range(0, 52) : $urandom_range(0, 62);
    if (r < 26) return "a" + r[7:0];
    if (r < 52) return "A" + r[7:0] - 8'd26;
    if (r == 52) return "_";
    return "0" + r[7:0] - 8'd53;
  endfunction

  task automatic send_blank();
    int unsigned b;
    repeat ($urandom_range(1, 2)) begin
      b = $urandom_range(8, 13);
      send_byte(b == 8 ? 8'd32 : b[7:0], 1'b0);
    end
  endtask

  task automatic send_lexeme();
    string ops = "+-*/(){};,";
    string kw_letters = "iflsewhnt";
    int    n;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: send_text("if");
          1: send_text("else");
          2: send_text("while");
          default: send_text("int");
        endcase
      end
      1, 2: begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
        send_byte(word_char(1'b1), 1'b0);
        repeat (n - 1) send_byte(word_char(1'b0), 1'b0);
      end
      3: repeat ($urandom_range(1, 6)) send_byte(kw_letters[$urandom_range(0, 8)], 1'b0);
      4, 5: begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 5);
        repeat (n) send_byte(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
      end
      6, 7: send_byte(ops[$urandom_range(0, 9)], 1'b0);
      8: begin
        case ($urandom_range(0, 2))
          0: send_text("=");
          1: send_text("==");
          default: send_text("!=");
        endcase
      end
      default: begin
        if ($urandom_range(0, 3) != 0) begin
          send_byte(ops[$urandom_range(0, 9)], 1'b0);
        end else begin
          case ($urandom_range(0, 2))
            0: send_text("!");
            1: send_byte(8'($urandom_range(0, 255)), 1'b0);
            default: send_byte(8'($urandom_range(128, 255)), 1'b0);
          endcase
        end
      end
    endcase
  endtask

  // Mostly well-formed sources with random content; some pure noise.
  task automatic send_source();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 20)) send_byte(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      repeat ($urandom_range(3, 25)) begin
        if ($urandom_range(0, 1) != 0) send_blank();
        send_lexeme();
      end
    end
    end_source();
  endtask

  task automatic test_keywords_and_operators();
    send_text("if(x==1){y=a+b-c*d/e;}else while int z,");
    for (int b = 9; b <= 13; b++) send_byte(8'(b), 1'b0);
    send_text(" Ifx _q9 whilex els a===b");
    end_source();
  endtask

  task automatic test_numbers();
    send_text("0 4294967295 4294967296 99999999999999 12ab 007;");
    end_source();
  endtask

  task automatic test_error_recovery();
    send_text("a!b c");
    end_source();
    send_text("!=x!");
    end_source();
    send_byte(8'h00, 1'b0);
    send_text("x");
    end_source();
    send_text("#x");
    end_source();
    send_byte(8'hFF, 1'b0);
    end_source();
    send_byte(8'h80, 1'b0);
    send_text("@");
    end_source();
  endtask

  task automatic test_end_flush();
    end_source();
    send_text("x=");
    end_source();
    send_text("abc");
    end_source();
    send_text("42");
    end_source();
  endtask

  task automatic test_random_sources();
    while (words_sent < RANDOM_WORDS) begin
      idling_on = ($urandom_range(0, 3) != 0);
      send_source();
    end
  endtask

  // Hold the output long enough for the queue to fill and stall the input.
  task automatic test_output_backpressure();
    int target;
    idling_on = 1'b0;
    target = words_sent + 100;
    hold_trigger++;
    while (words_sent < target) send_source();
  endtask

  task automatic test_random_no_idle();
    idling_on = 1'b0;
    while (words_sent < TOTAL_WORDS) send_source();
  endtask

  initial begin
    rewind_lexer();
    repeat (2) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    test_keywords_and_operators();
    test_numbers();
    test_error_recovery();
    test_end_flush();
    test_random_sources();
    test_output_backpressure();
    test_random_no_idle();
    in_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_tokens.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
